// ----- sv/tcst_pkg.sv -----
`default_nettype none

package tcst_pkg;

    localparam int CONN_SLOTS = 4096;
    localparam int SLOT_W     = $clog2(CONN_SLOTS);
    localparam int TICK_SHIFT = 8;

    localparam int N_STATES = 11;
    localparam int STATE_W  = 4;
    localparam int SECS_W   = 16;
    localparam int DELAY_W  = 32;

    typedef logic [STATE_W-1:0] state_t;

    localparam state_t ST_NONE   = 4'd0;
    localparam state_t ST_EST    = 4'd1;
    localparam state_t ST_SYNACK = 4'd10;
    localparam state_t ST_CLOSE  = 4'd6;

    // tcp flag bit positions
    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 4;

    // transition row groups and events inside a group
    typedef enum logic [1:0] {
        ROW_IN     = 2'd0,
        ROW_OUT    = 2'd1,
        ROW_INONLY = 2'd2
    } row_t;

    typedef enum logic [1:0] {
        EV_SYN = 2'd0,
        EV_FIN = 2'd1,
        EV_ACK = 2'd2,
        EV_RST = 2'd3
    } event_t;

    localparam logic [1:0] DIR_IN  = 2'd0;
    localparam logic [1:0] DIR_OUT = 2'd1;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_OPEN   = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_NOSUP = 1'b1;

    // next state, indexed by {row group, event} then current state
    localparam state_t NEXT_TAB [0:11][0:N_STATES-1] = '{
        '{4'd3, 4'd1, 4'd1, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
        '{4'd6, 4'd7, 4'd2, 4'd5, 4'd5, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5},
        '{4'd6, 4'd1, 4'd2, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7, 4'd6, 4'd9, 4'd1},
        '{4'd6, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd9, 4'd3},
        '{4'd2, 4'd1, 4'd2, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd9, 4'd3},
        '{4'd5, 4'd4, 4'd2, 4'd5, 4'd4, 4'd5, 4'd6, 4'd5, 4'd8, 4'd9, 4'd5},
        '{4'd1, 4'd1, 4'd2, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd1, 4'd1},
        '{4'd6, 4'd6, 4'd2, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
        '{4'd3, 4'd1, 4'd1, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
        '{4'd6, 4'd4, 4'd2, 4'd5, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5},
        '{4'd6, 4'd1, 4'd2, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7, 4'd6, 4'd9, 4'd1},
        '{4'd6, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd9, 4'd6}
    };

    function automatic state_t sat_state(input state_t st);
        sat_state = (st > ST_SYNACK) ? ST_SYNACK : st;
    endfunction

endpackage

`default_nettype wire

// ----- sv/tcp_conn_state_tracker.sv -----
`default_nettype none

// tcp connection state tracker
// s_ channel takes one word per item: s_tuser carries the opcode (0 packet
// event, 1 open slot), s_tdata the slot index, tcp flags, direction, direct
// mode flag, destination timeout and open state. m_ channel returns exactly
// one word per item: status, new state, changed flag and timer delay.
// timeouts are set through cfg_we/cfg_index/cfg_data; the user must do so
// only while no item is in flight, the block does not enforce it. index 0..2
// selects the three per-state timeout registers. the per-slot state lives in
// a one-port-read, one-port-write ram with a registered read. an item reads
// its slot at acceptance and writes the updated state back as it leaves the
// read stage; a back-to-back hit on the same slot takes the value being
// written instead of the stale ram word. throughput: one item per cycle,
// limited by the single ram read-modify-write. if m_tready is low the result
// holds in the output register, the next item waits in the read stage and
// s_tready drops until the output frees up. reset clears the pipeline valids
// and the timeout registers; the state ram is not cleared, each slot must be
// opened before packets refer to it.
module tcp_conn_state_tracker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // conn_index[11:0], flag_bits[19:12], direction[21:20], direct_mode[22],
    // dest_timeout[54:23], open_state[58:55], zero fill[63:59]
    input  wire logic [63:0]         s_tdata,
    // opcode[0]
    input  wire logic [0:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status[0], state_after[4:1], changed[5], timer_delay[37:6], zero fill[39:38]
    output logic [39:0]              m_tdata,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [63:0]         cfg_data
);
    import tcst_pkg::*;

    localparam logic [1:0] CFG_TO_0_3  = 2'd0;
    localparam logic [1:0] CFG_TO_4_7  = 2'd1;
    localparam logic [1:0] CFG_TO_8_10 = 2'd2;

    // timeout registers
    logic [63:0] to03_reg;
    logic [63:0] to47_reg;
    logic [47:0] to810_reg;

    // input field unpack
    logic [SLOT_W-1:0]  in_slot;
    logic [7:0]         in_flags;
    logic [1:0]         in_dir;
    logic               in_direct;
    logic [DELAY_W-1:0] in_dest_to;
    state_t             in_open_st;

    assign in_slot    = s_tdata[SLOT_W-1:0];
    assign in_flags   = s_tdata[19:12];
    assign in_dir     = s_tdata[21:20];
    assign in_direct  = s_tdata[22];
    assign in_dest_to = s_tdata[54:23];
    assign in_open_st = s_tdata[58:55];

    // state ram
    state_t state_mem [CONN_SLOTS];
    state_t rdata_reg;

    // read stage registers
    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic [7:0]         s1_flags_reg;
    logic [1:0]         s1_dir_reg;
    logic               s1_direct_reg;
    logic [DELAY_W-1:0] s1_dest_to_reg;
    state_t             s1_open_st_reg;
    logic               fwd_hit_reg;
    state_t             fwd_val_reg;

    // output register
    logic               m_valid_reg;
    logic [39:0]        m_data_reg;

    logic               s_accept;
    logic               s1_fire;
    logic               s1_wr;
    state_t             s1_wdata;
    state_t             cur_st;
    state_t             open_sat;
    state_t             nxt_st;
    logic               row_ok;
    row_t               row_sel;
    event_t             ev_sel;
    logic               ev_none;
    logic [3:0]         tab_idx;
    logic               res_status;
    state_t             res_state;
    logic               res_changed;
    logic [DELAY_W-1:0] res_delay;
    logic [175:0]       all_to;
    logic [SECS_W-1:0]  nxt_secs;
    logic [7:0]         secs_base;
    logic               fwd_hit_next;

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            to03_reg  <= '0;
            to47_reg  <= '0;
            to810_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TO_0_3:  to03_reg  <= cfg_data;
                CFG_TO_4_7:  to47_reg  <= cfg_data;
                CFG_TO_8_10: to810_reg <= cfg_data[47:0];
                default:     ;
            endcase
        end
    end

    // transition lookup for the word in the read stage
    always_comb begin
        cur_st   = sat_state(fwd_hit_reg ? fwd_val_reg : rdata_reg);
        open_sat = sat_state(s1_open_st_reg);

        row_ok  = 1'b1;
        row_sel = ROW_IN;
        if (s1_direct_reg) begin
            row_sel = ROW_INONLY;
        end else if (s1_dir_reg == DIR_IN) begin
            row_sel = ROW_IN;
        end else if (s1_dir_reg == DIR_OUT) begin
            row_sel = ROW_OUT;
        end else begin
            row_ok = 1'b0;
        end

        ev_none = 1'b0;
        ev_sel  = EV_SYN;
        if (s1_flags_reg[FLAG_RST]) begin
            ev_sel = EV_RST;
        end else if (s1_flags_reg[FLAG_SYN]) begin
            ev_sel = EV_SYN;
        end else if (s1_flags_reg[FLAG_FIN]) begin
            ev_sel = EV_FIN;
        end else if (s1_flags_reg[FLAG_ACK]) begin
            ev_sel = EV_ACK;
        end else begin
            ev_none = 1'b1;
        end

        tab_idx = {row_sel, ev_sel};
        nxt_st  = ev_none ? ST_CLOSE : NEXT_TAB[tab_idx][cur_st];

        all_to    = {to810_reg, to47_reg, to03_reg};
        secs_base = {nxt_st, 4'b0000};
        nxt_secs  = all_to[secs_base +: SECS_W];

        res_status  = STATUS_OK;
        res_state   = cur_st;
        res_changed = 1'b0;
        res_delay   = '0;
        s1_wr       = 1'b0;
        s1_wdata    = open_sat;
        if (s1_op_reg == OP_OPEN) begin
            res_state = open_sat;
            s1_wr     = 1'b1;
        end else if (!row_ok) begin
            res_status = STATUS_NOSUP;
        end else if (nxt_st != cur_st) begin
            res_state   = nxt_st;
            res_changed = 1'b1;
            s1_wr       = 1'b1;
            s1_wdata    = nxt_st;
            if (nxt_st == ST_EST && s1_dest_to_reg != '0) begin
                res_delay = s1_dest_to_reg;
            end else begin
                res_delay = DELAY_W'({{(DELAY_W - SECS_W){1'b0}}, nxt_secs} << TICK_SHIFT);
            end
        end
    end

    // the ram read at this edge misses the write-back of the word ahead
    assign fwd_hit_next = s1_valid_reg && s1_wr && (s1_slot_reg == in_slot);

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_wr) begin
            state_mem[s1_slot_reg] <= s1_wdata;
        end
        if (s_accept) begin
            rdata_reg <= state_mem[in_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg      <= s_tuser[0];
            s1_slot_reg    <= in_slot;
            s1_flags_reg   <= in_flags;
            s1_dir_reg     <= in_dir;
            s1_direct_reg  <= in_direct;
            s1_dest_to_reg <= in_dest_to;
            s1_open_st_reg <= in_open_st;
            fwd_hit_reg    <= fwd_hit_next;
            fwd_val_reg    <= s1_wdata;
        end
        if (s1_fire) begin
            m_data_reg <= {2'b00, res_delay, res_changed, res_state, res_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ----- dv/conn_tb_pkg.sv -----
package conn_tb_pkg;

    // register indexes of the timeout registers
    localparam logic [1:0] REG_TMO_0_3  = 2'd0;
    localparam logic [1:0] REG_TMO_4_7  = 2'd1;
    localparam logic [1:0] REG_TMO_8_10 = 2'd2;

    // direction codes with no row of their own
    localparam logic [1:0] DIR_INONLY = 2'd2;
    localparam logic [1:0] DIR_RSVD   = 2'd3;

    localparam logic [7:0] TCP_FIN = 8'd1 << tcst_pkg::FLAG_FIN;
    localparam logic [7:0] TCP_SYN = 8'd1 << tcst_pkg::FLAG_SYN;
    localparam logic [7:0] TCP_RST = 8'd1 << tcst_pkg::FLAG_RST;
    localparam logic [7:0] TCP_ACK = 8'd1 << tcst_pkg::FLAG_ACK;
    localparam logic [7:0] TCP_EVENT_MASK = TCP_FIN | TCP_SYN | TCP_RST | TCP_ACK;

    // s_tdata payload, msb first so conn_index lands in the low bits
    typedef struct packed {
        logic [3:0]  open_state;
        logic [31:0] dest_timeout;
        logic        direct_mode;
        logic [1:0]  direction;
        logic [7:0]  flag_bits;
        logic [11:0] conn_index;
    } conn_fields_t;

    // m_tdata payload, status in bit 0
    typedef struct packed {
        logic [31:0]      timer_delay;
        logic             changed;
        tcst_pkg::state_t state_after;
        logic             status;
    } conn_result_t;

endpackage

// ----- dv/conn_state_checker.sv -----
module conn_state_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // conn_index, flag_bits, direction, direct_mode, dest_timeout, open_state
    input  wire logic [63:0] s_tdata,
    // opcode
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // status, state_after, changed, timer_delay
    input  wire logic [39:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output int               failures,
    output int               outstanding,
    output int               words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcst_pkg::*;
    import conn_tb_pkg::*;

    // rows: {group, event} with event order syn, fin, ack, rst; columns: current state
    localparam state_t TRANSITIONS [0:11][0:10] = '{
        '{4'd3, 4'd1, 4'd1, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
        '{4'd6, 4'd7, 4'd2, 4'd5, 4'd5, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5},
        '{4'd6, 4'd1, 4'd2, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7, 4'd6, 4'd9, 4'd1},
        '{4'd6, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd9, 4'd3},
        '{4'd2, 4'd1, 4'd2, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd9, 4'd3},
        '{4'd5, 4'd4, 4'd2, 4'd5, 4'd4, 4'd5, 4'd6, 4'd5, 4'd8, 4'd9, 4'd5},
        '{4'd1, 4'd1, 4'd2, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd1, 4'd1},
        '{4'd6, 4'd6, 4'd2, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
        '{4'd3, 4'd1, 4'd1, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
        '{4'd6, 4'd4, 4'd2, 4'd5, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5},
        '{4'd6, 4'd1, 4'd2, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7, 4'd6, 4'd9, 4'd1},
        '{4'd6, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd9, 4'd6}
    };

    state_t       slot_state [0:CONN_SLOTS-1];
    logic [63:0]  tmo_0_3  = '0;
    logic [63:0]  tmo_4_7  = '0;
    logic [47:0]  tmo_8_10 = '0;
    conn_result_t expected_results [$];
    int           fail_count = 0;
    int           checked_count = 0;

    assign failures      = fail_count;
    assign outstanding   = expected_results.size();
    assign words_checked = checked_count;

    function automatic conn_result_t predict_conn(input logic op, input conn_fields_t f);
        state_t       cur;
        state_t       nxt;
        row_t         grp;
        event_t       ev;
        conn_result_t r;
        logic [175:0] all_secs;
        logic [47:0]  ticks;
        int           lane;
        cur = slot_state[f.conn_index];
        if (cur > ST_SYNACK) cur = ST_SYNACK;
        r = '{timer_delay: 32'd0, changed: 1'b0, state_after: cur, status: STATUS_OK};
        if (op == OP_OPEN) begin
            nxt = (f.open_state > ST_SYNACK) ? ST_SYNACK : f.open_state;
            slot_state[f.conn_index] = nxt;
            r.state_after = nxt;
            return r;
        end
        if (f.direct_mode) grp = ROW_INONLY;
        else if (f.direction == DIR_IN) grp = ROW_IN;
        else if (f.direction == DIR_OUT) grp = ROW_OUT;
        else begin
            r.status = STATUS_NOSUP;
            return r;
        end
        if (f.flag_bits & TCP_RST) ev = EV_RST;
        else if (f.flag_bits & TCP_SYN) ev = EV_SYN;
        else if (f.flag_bits & TCP_FIN) ev = EV_FIN;
        else ev = EV_ACK;
        if (f.flag_bits & TCP_EVENT_MASK) nxt = TRANSITIONS[{grp, ev}][cur];
        else nxt = ST_CLOSE;
        if (nxt == cur) return r;
        slot_state[f.conn_index] = nxt;
        r.state_after = nxt;
        r.changed     = 1'b1;
        if (nxt == ST_EST && f.dest_timeout != 0) begin
            r.timer_delay = f.dest_timeout;
        end else begin
            all_secs = {tmo_8_10, tmo_4_7, tmo_0_3};
            lane = nxt;
            ticks = 48'(all_secs[lane*16 +: 16]) << TICK_SHIFT;
            r.timer_delay = ticks[31:0];
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d (0x%h), actual %0d (0x%h)",
                   name, want, want, got, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        conn_result_t got;
        conn_result_t want;
        if (!aresetn) begin
            tmo_0_3  <= '0;
            tmo_4_7  <= '0;
            tmo_8_10 <= '0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[37:0];
                if (expected_results.size() == 0) begin
                    $error("result word 0x%h with nothing expected", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("state_after", want.state_after, got.state_after);
                    check_field("changed", want.changed, got.changed);
                    check_field("timer_delay", want.timer_delay, got.timer_delay);
                    checked_count++;
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_conn(s_tuser[0], s_tdata[58:0]));
            if (cfg_we) begin
                case (cfg_index)
                    REG_TMO_0_3:  tmo_0_3  <= cfg_data;
                    REG_TMO_4_7:  tmo_4_7  <= cfg_data;
                    REG_TMO_8_10: tmo_8_10 <= cfg_data[47:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- dv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcst_pkg::*;
    import conn_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 280;
    localparam int POOL_SLOTS   = 12;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [63:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;
    int          failures;
    int          outstanding;
    int          words_checked;

    bit          slot_open [0:CONN_SLOTS-1];
    logic [11:0] slot_pool [0:POOL_SLOTS-1];
    bit          steady = 1'b0;
    int          cycles = 0;
    int          stall_left = 0;
    int          items_sent = 0;
    int          opens_sent = 0;
    int          packets_sent = 0;
    int          nosup_sent = 0;
    int          settings_used = 0;

    always #5 aclk = ~aclk;

    tcp_conn_state_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    conn_state_checker conn_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short idles, now and then a long one, none while steady
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    function automatic conn_fields_t noise_fields();
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        return noise[58:0];
    endfunction

    task automatic send_word(input logic op, input conn_fields_t f);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, f};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic open_slot(input logic [11:0] idx, input logic [3:0] st);
        conn_fields_t f;
        f = noise_fields();
        f.conn_index = idx;
        f.open_state = st;
        send_word(OP_OPEN, f);
        slot_open[idx] = 1'b1;
        opens_sent++;
    endtask

    task automatic send_packet(input logic [11:0] idx, input logic [7:0] flags,
                               input logic [1:0] dir, input logic direct,
                               input logic [31:0] dest);
        conn_fields_t f;
        f = noise_fields();
        f.conn_index   = idx;
        f.flag_bits    = flags;
        f.direction    = dir;
        f.direct_mode  = direct;
        f.dest_timeout = dest;
        send_word(OP_PACKET, f);
        packets_sent++;
        if (!direct && dir > DIR_OUT) nosup_sent++;
    endtask

    // drops valid and waits for every result, plus idle slack
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_timeouts(input logic [63:0] t03, input logic [63:0] t47,
                                  input logic [63:0] t810);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TMO_0_3;
        cfg_data  <= t03;
        @(negedge aclk);
        cfg_index <= REG_TMO_4_7;
        cfg_data  <= t47;
        @(negedge aclk);
        cfg_index <= REG_TMO_8_10;
        cfg_data  <= t810;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    task automatic random_item();
        logic [11:0] idx;
        logic [7:0]  flags;
        logic [1:0]  dir;
        logic [31:0] dest;
        int          r;
        idx = slot_pool[$urandom_range(0, POOL_SLOTS - 1)];
        if (!slot_open[idx] || $urandom_range(0, 99) < 10) begin
            if ($urandom_range(0, 9) == 0) open_slot(idx, 4'($urandom));
            else open_slot(idx, 4'($urandom_range(0, 10)));
            return;
        end
        case ($urandom_range(0, 9))
            0, 1:    flags = TCP_SYN;
            2:       flags = TCP_SYN | TCP_ACK;
            3, 4:    flags = TCP_ACK;
            5:       flags = TCP_FIN | TCP_ACK;
            6:       flags = TCP_FIN;
            7:       flags = TCP_RST | (8'($urandom) & TCP_ACK);
            8:       flags = 8'($urandom) & ~TCP_EVENT_MASK;
            default: flags = 8'($urandom);
        endcase
        r = $urandom_range(0, 99);
        if (r < 45) dir = DIR_IN;
        else if (r < 90) dir = DIR_OUT;
        else dir = 2'($urandom_range(DIR_INONLY, DIR_RSVD));
        r = $urandom_range(0, 99);
        if (r < 40) dest = '0;
        else if (r < 50) dest = '1;
        else dest = $urandom;
        send_packet(idx, flags, dir, $urandom_range(0, 99) < 20, dest);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // distinct lanes so a wrong lane pick shows up
        write_timeouts(64'hFFFF_0001_8000_00FF, 64'h0123_4567_89AB_CDEF,
                       64'hFFFF_7FFF_0100_FFFE);

        open_slot(12'h000, 4'd0);
        open_slot(12'hFFF, 4'd15);
        open_slot(12'h555, 4'd1);
        open_slot(12'hAAA, 4'd9);
        send_packet(12'h000, TCP_SYN, DIR_IN, 1'b0, 32'd100);
        send_packet(12'h000, TCP_ACK, DIR_IN, 1'b0, 32'hFFFF_FFFF);
        send_packet(12'h000, TCP_ACK, DIR_IN, 1'b0, 32'd7);
        send_packet(12'h000, TCP_FIN, DIR_OUT, 1'b0, 32'd0);
        // push flag only: none of the four event flags
        send_packet(12'h000, 8'h08, DIR_IN, 1'b0, 32'd0);
        send_packet(12'h000, 8'hFF, DIR_IN, 1'b0, 32'd0);
        send_packet(12'hFFF, TCP_SYN, DIR_INONLY, 1'b0, 32'd0);
        send_packet(12'hFFF, TCP_SYN, DIR_RSVD, 1'b0, 32'd0);
        send_packet(12'hFFF, TCP_SYN, DIR_RSVD, 1'b1, 32'd0);
        send_packet(12'hFFF, TCP_ACK, DIR_IN, 1'b1, 32'd0);
        open_slot(12'h555, 4'd2);
        send_packet(12'h555, TCP_SYN | TCP_ACK | TCP_FIN, DIR_IN, 1'b0, 32'd0);
        send_packet(12'h555, TCP_FIN | TCP_ACK, DIR_IN, 1'b0, 32'd0);
        send_packet(12'hAAA, TCP_RST | TCP_SYN, DIR_OUT, 1'b0, 32'd0);
        open_slot(12'hAAA, 4'd10);
        send_packet(12'hAAA, TCP_ACK, DIR_OUT, 1'b1, 32'd5);
        open_slot(12'h123, 4'd8);
        send_packet(12'h123, TCP_FIN, DIR_IN, 1'b0, 32'd0);
        send_packet(12'h123, TCP_ACK, DIR_IN, 1'b0, 32'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: write_timeouts('1, '1, '1);
                1: write_timeouts('0, '0, '0);
                default: write_timeouts({$urandom, $urandom}, {$urandom, $urandom},
                                        {$urandom, $urandom});
            endcase
            for (int k = 0; k < POOL_SLOTS; k++) slot_pool[k] = 12'($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                steady = (n >= 200 && n < 240);
                if (n == 140) wait_idle();
                random_item();
            end
        end
        steady = 1'b0;
        wait_idle();
        repeat (10) @(negedge aclk);

        $display("sent %0d words: %0d slot opens, %0d packets (%0d on unsupported directions)",
                 items_sent, opens_sent, packets_sent, nosup_sent);
        $display("%0d timeout settings incl. all-zero and all-ones, %0d results compared",
                 settings_used, words_checked);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/tcst_pkg.sv
sv/tcp_conn_state_tracker.sv
dv/conn_tb_pkg.sv
dv/conn_state_checker.sv
dv/testbench.sv
